/* hdl/sctfc_pkg.sv */
// Shared types and constants of the sampling cycle fan and tape controller.
// Holds the command codes, the state record and the result record.
// Depends on nothing; every other file imports it.
`default_nettype none

package sctfc_pkg;

   localparam int TICKS_PER_SECOND  = 5000;
   localparam int STEPS_PER_ADVANCE = 200;

   localparam int PRESCALER_W = $clog2(TICKS_PER_SECOND);
   localparam int HALFSTEP_W  = $clog2(2 * STEPS_PER_ADVANCE);
   localparam int SECONDS_W   = 12;
   localparam int INTERVAL_W  = 6;
   localparam int FLOW_W      = 8;
   localparam int DUTY_W      = 8;
   localparam int MINUTES_W   = 16;
   localparam int FLOW_IN_W   = 13;

   localparam logic [MINUTES_W-1:0]  MIN_INTERVAL = MINUTES_W'(15);
   localparam logic [MINUTES_W-1:0]  MAX_INTERVAL = MINUTES_W'(60);
   localparam logic [FLOW_IN_W-1:0]  MAX_FLOW_Q4  = FLOW_IN_W'(240);
   localparam logic [SECONDS_W-1:0]  SECONDS_MAX  = {SECONDS_W{1'b1}};
   localparam logic [SECONDS_W-1:0]  SECONDS_PER_MINUTE = SECONDS_W'(60);
   localparam logic [PRESCALER_W:0]  TICKS_LIMIT  = (PRESCALER_W + 1)'(TICKS_PER_SECOND);
   localparam logic [HALFSTEP_W-1:0] BURST_LOAD   =
      HALFSTEP_W'(2 * STEPS_PER_ADVANCE - 1);

   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_START    = 2'd1,
      OP_STOP     = 2'd2,
      OP_SET_FLOW = 2'd3
   } op_type;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAN_ENABLED   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTOR_ENABLED = 1'b1;

   typedef struct packed {
      logic [PRESCALER_W-1:0] prescaler;
      logic [SECONDS_W-1:0]   seconds;
      logic [INTERVAL_W-1:0]  interval;
      logic                   active;
      logic [FLOW_W-1:0]      flow;
      logic [HALFSTEP_W-1:0]  halfsteps;
      logic                   step_pin;
      logic                   dir_pin;
   } state_type;

   typedef struct packed {
      logic [DUTY_W-1:0] fan_duty;
      logic              step_level;
      logic              direction;
      logic              sampling_active;
      logic              tape_busy;
   } result_type;

endpackage

`default_nettype wire

/* hdl/sctfc_if.sv */
// Request and response channel interfaces of the sampling cycle fan and tape controller.
// Each carries valid, ready and the payload fields. Depends on sctfc_pkg.
`default_nettype none

interface sctfc_req_if
   import sctfc_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   op_type                      op;
   logic [MINUTES_W-1:0]        interval_minutes;
   logic signed [FLOW_IN_W-1:0] flow_rate;

   modport source (output valid, output op, output interval_minutes, output flow_rate,
                   input ready);
   modport sink (input valid, input op, input interval_minutes, input flow_rate,
                 output ready);
endinterface

interface sctfc_rsp_if
   import sctfc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DUTY_W-1:0] fan_duty;
   logic              step_level;
   logic              direction;
   logic              sampling_active;
   logic              tape_busy;

   modport source (output valid, output fan_duty, output step_level, output direction,
                   output sampling_active, output tape_busy, input ready);
   modport sink (input valid, input fan_duty, input step_level, input direction,
                 input sampling_active, input tape_busy, output ready);
endinterface

`default_nettype wire

/* hdl/sampling_cycle_fan_tape_controller_unit.sv */
// Top level of the sampling cycle fan and tape controller.
// Holds the state, configuration and response registers; uses sctfc_pkg, sctfc_if, sctfc_next.
//
//   channel   direction  handshake       payload
//   req_chan  in         valid / ready   op, interval_minutes, flow_rate
//   rsp_chan  out        valid / ready   fan_duty, step_level, direction,
//                                        sampling_active, tape_busy
//   csr_*     in         write enable    csr_index, csr_write_data
//
// Every request yields one response, registered and presented in the cycle after acceptance.
// A request is taken every cycle as long as the response register is empty or being drained.
// When the response is stalled, the request side stalls with it and nothing is lost.
// Reset is synchronous and clears the state, the configuration and the response valid.
`default_nettype none

module sampling_cycle_fan_tape_controller_unit
   import sctfc_pkg::*;
(
   input  var logic                   clock,
   input  var logic                   reset,
   sctfc_req_if.sink                  req_chan,
   sctfc_rsp_if.source                rsp_chan,
   input  var logic                   csr_write_enable,
   input  var logic [CSR_INDEX_W-1:0] csr_index,
   input  var logic [CSR_DATA_W-1:0]  csr_write_data
);

   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;
   logic       rsp_valid_ff;
   logic       fan_enabled_ff;
   logic       motor_enabled_ff;
   logic       req_take;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   sctfc_next u_next (
      .state_cur        (state_ff),
      .op               (req_chan.op),
      .interval_minutes (req_chan.interval_minutes),
      .flow_rate        (req_chan.flow_rate),
      .fan_enabled      (fan_enabled_ff),
      .motor_enabled    (motor_enabled_ff),
      .state_nxt        (state_in),
      .result           (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
         fan_enabled_ff   <= 1'b0;
         motor_enabled_ff <= 1'b0;
      end else begin
         if (req_take) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_FAN_ENABLED:   fan_enabled_ff   <= csr_write_data[0];
               CSR_MOTOR_ENABLED: motor_enabled_ff <= csr_write_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.fan_duty        = result_ff.fan_duty;
   assign rsp_chan.step_level      = result_ff.step_level;
   assign rsp_chan.direction       = result_ff.direction;
   assign rsp_chan.sampling_active = result_ff.sampling_active;
   assign rsp_chan.tape_busy       = result_ff.tape_busy;

`ifndef ASSERT_OFF
   a_prescaler_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, state_ff.prescaler} < TICKS_LIMIT)
      else $error("prescaler out of range");

   a_burst_sets_direction: assert property (@(posedge clock) disable iff (reset)
      state_ff.halfsteps != '0 |-> state_ff.dir_pin)
      else $error("burst running without direction high");

   a_request_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_busy_matches_state: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (rsp_chan.tape_busy == (state_ff.halfsteps != '0)))
      else $error("tape busy does not match burst state");
`endif

endmodule

`default_nettype wire

/* hdl/sctfc_next.sv */
// Next-state and result logic of the sampling cycle fan and tape controller.
// Purely combinational: one request against the current state. Depends on sctfc_pkg.
`default_nettype none

module sctfc_next
   import sctfc_pkg::*;
(
   input  var state_type                   state_cur,
   input  var op_type                      op,
   input  var logic [MINUTES_W-1:0]        interval_minutes,
   input  var logic signed [FLOW_IN_W-1:0] flow_rate,
   input  var logic                        fan_enabled,
   input  var logic                        motor_enabled,
   output state_type                       state_nxt,
   output result_type                      result
);

   logic [PRESCALER_W:0]  pre_inc;
   logic                  wrapped;
   logic                  busy;
   logic [SECONDS_W-1:0]  interval_seconds;
   logic [MINUTES_W-1:0]  minutes_clamped;
   logic [FLOW_IN_W-1:0]  flow_clamped;
   logic [DUTY_W+3:0]     duty_wide;

   assign pre_inc = {1'b0, state_cur.prescaler} + (PRESCALER_W + 1)'(1);
   assign wrapped = pre_inc >= TICKS_LIMIT;
   assign busy    = state_cur.halfsteps != '0;
   assign interval_seconds =
      SECONDS_W'({{(SECONDS_W - INTERVAL_W){1'b0}}, state_cur.interval} * SECONDS_PER_MINUTE);

   always_comb begin
      if (interval_minutes < MIN_INTERVAL) begin
         minutes_clamped = MIN_INTERVAL;
      end else if (interval_minutes > MAX_INTERVAL) begin
         minutes_clamped = MAX_INTERVAL;
      end else begin
         minutes_clamped = interval_minutes;
      end

      if (flow_rate[FLOW_IN_W-1]) begin
         flow_clamped = '0;
      end else if (flow_rate > $signed(MAX_FLOW_Q4)) begin
         flow_clamped = MAX_FLOW_Q4;
      end else begin
         flow_clamped = flow_rate;
      end
   end

   always_comb begin
      state_nxt = state_cur;
      unique case (op)
         OP_TICK: begin
            state_nxt.prescaler = wrapped ? '0 : pre_inc[PRESCALER_W-1:0];
            if (state_cur.active && wrapped && state_cur.seconds != SECONDS_MAX) begin
               state_nxt.seconds = state_cur.seconds + SECONDS_W'(1);
            end
            if (busy) begin
               state_nxt.step_pin  = ~state_cur.step_pin;
               state_nxt.halfsteps = state_cur.halfsteps - HALFSTEP_W'(1);
            end
            if (state_cur.active && state_nxt.seconds >= interval_seconds) begin
               state_nxt.seconds = '0;
               if (!busy && motor_enabled) begin
                  state_nxt.dir_pin   = 1'b1;
                  state_nxt.step_pin  = 1'b1;
                  state_nxt.halfsteps = BURST_LOAD;
               end
            end
         end
         OP_START: begin
            state_nxt.interval = minutes_clamped[INTERVAL_W-1:0];
            state_nxt.active   = 1'b1;
            state_nxt.seconds  = '0;
         end
         OP_STOP: begin
            state_nxt.active = 1'b0;
            state_nxt.flow   = '0;
         end
         OP_SET_FLOW: begin
            state_nxt.flow = flow_clamped[FLOW_W-1:0];
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

   // Duty is flow * 17 / 16, i.e. (flow * 16 + flow) >> 4.
   assign duty_wide = {state_nxt.flow, 4'b0000} + {4'b0000, state_nxt.flow};

   always_comb begin
      result.fan_duty        = fan_enabled ? duty_wide[DUTY_W+3:4] : '0;
      result.step_level      = state_nxt.step_pin;
      result.direction       = state_nxt.dir_pin;
      result.sampling_active = state_nxt.active;
      result.tape_busy       = state_nxt.halfsteps != '0;
   end

endmodule

`default_nettype wire
